### rtl/epda_pkg.sv
package epda_pkg;

    localparam int TimerW       = 16;
    localparam int WindowLenDef = 5;

    localparam logic [15:0] PrefillTicks = 16'd15000;
    localparam logic [9:0]  ThresholdRst = 10'd70;

    localparam logic [7:0]  ScaleNum = 8'd254;
    localparam logic [7:0]  ScaleDen = 8'd147;
    // 254 * 16, the distance numerator with four fraction bits.
    localparam logic [11:0] DistMul  = 12'd4064;
    // floor(4064 * 2^16 / 147); the estimate it gives is low by at most one.
    localparam logic [20:0] DistRecip      = 21'd1811825;
    localparam int          DistRecipShift = 16;

    typedef struct packed {
        logic [15:0] avg;
        logic [15:0] pulse;
    } t_avg_item;

    typedef struct packed {
        logic        near;
        logic [20:0] dist_q4;
        logic [15:0] avg;
        logic [15:0] pulse;
    } t_result;

endpackage

### rtl/epda_ring.sv
module epda_ring
    import epda_pkg::*;
#(
    parameter int WINDOW_LENGTH = WindowLenDef,
    parameter int SlotW         = 3,
    parameter int SumW          = 19
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_vld,
    output logic              o_rdy,
    input  logic [15:0]       i_dur,
    input  logic [SlotW-1:0]  i_addr,
    output logic              o_vld,
    input  logic              i_rdy,
    output logic [SumW-1:0]   o_sum,
    output logic [15:0]       o_dur
);

    localparam logic [63:0]     SumRstFull = 64'(PrefillTicks) * 64'(WINDOW_LENGTH);
    localparam logic [SumW-1:0] SumRst     = SumRstFull[SumW-1:0];

    logic [15:0]              r_mem [WINDOW_LENGTH];
    logic [15:0]              r_rd_data;
    logic                     r_s2_vld;
    logic [15:0]              r_s2_dur;
    logic [SlotW-1:0]         r_s2_addr;
    logic                     r_fwd_vld;
    logic [SlotW-1:0]         r_fwd_addr;
    logic [15:0]              r_fwd_data;
    logic [WINDOW_LENGTH-1:0] r_ent_vld;
    logic [SumW-1:0]          r_sum;
    logic                     r_o_vld;
    logic [SumW-1:0]          r_o_sum;
    logic [15:0]              r_o_dur;

    logic             en_out;
    logic             en_s2;
    logic             retire;
    logic [15:0]      old_val;
    logic [SumW-1:0]  n_sum;

    assign en_out = !r_o_vld || i_rdy;
    assign en_s2  = !r_s2_vld || en_out;
    assign retire = r_s2_vld && en_out;
    assign o_rdy  = en_s2;

    // The write of the item ahead lands on the same edge as this item's read,
    // so the last write is forwarded when it hit the same entry.
    always_comb begin
        if (r_fwd_vld && (r_fwd_addr == r_s2_addr)) begin
            old_val = r_fwd_data;
        end else if (r_ent_vld[r_s2_addr]) begin
            old_val = r_rd_data;
        end else begin
            old_val = PrefillTicks;
        end
    end

    assign n_sum = r_sum - SumW'(old_val) + SumW'(r_s2_dur);

    always_ff @(posedge i_clk) begin
        if (i_vld && en_s2) begin
            r_rd_data <= r_mem[i_addr];
        end
        if (retire) begin
            r_mem[r_s2_addr] <= r_s2_dur;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_s2) begin
            r_s2_dur  <= i_dur;
            r_s2_addr <= i_addr;
        end
        if (retire) begin
            r_fwd_addr <= r_s2_addr;
            r_fwd_data <= r_s2_dur;
            r_o_sum    <= n_sum;
            r_o_dur    <= r_s2_dur;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld  <= 1'b0;
            r_fwd_vld <= 1'b0;
            r_ent_vld <= '0;
            r_sum     <= SumRst;
            r_o_vld   <= 1'b0;
        end else begin
            if (en_s2) begin
                r_s2_vld <= i_vld;
            end
            if (retire) begin
                r_fwd_vld            <= 1'b1;
                r_ent_vld[r_s2_addr] <= 1'b1;
                r_sum                <= n_sum;
            end
            if (en_out) begin
                r_o_vld <= r_s2_vld;
            end
        end
    end

    assign o_vld = r_o_vld;
    assign o_sum = r_o_sum;
    assign o_dur = r_o_dur;

endmodule

### rtl/epda_div.sv
module epda_div
    import epda_pkg::*;
#(
    parameter int WINDOW_LENGTH = WindowLenDef,
    parameter int SumW          = 19
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_vld,
    output logic            o_rdy,
    input  logic [SumW-1:0] i_sum,
    input  logic [15:0]     i_dur,
    output logic            o_vld,
    input  logic            i_rdy,
    output t_avg_item       o_item
);

    localparam logic [63:0]     RecipFull = (64'd1 << SumW) / 64'(WINDOW_LENGTH);
    localparam logic [SumW:0]   RecipM    = RecipFull[SumW:0];
    localparam logic [63:0]     WinFull   = 64'(WINDOW_LENGTH);
    localparam logic [SumW:0]   WinW      = WinFull[SumW:0];
    localparam logic [SumW-1:0] WinS      = WinFull[SumW-1:0];

    logic                r_a_vld;
    logic [2*SumW:0]     r_a_prod;
    logic [SumW-1:0]     r_a_sum;
    logic [15:0]         r_a_dur;
    logic                r_b_vld;
    t_avg_item           r_b_item;

    logic                en_b;
    logic                en_a;
    logic [SumW:0]       q_est;
    logic [2*SumW+1:0]   q_mul;
    logic [SumW-1:0]     rem;
    logic [SumW:0]       q_fin;

    assign en_b  = !r_b_vld || i_rdy;
    assign en_a  = !r_a_vld || en_b;
    assign o_rdy = en_a;

    assign q_est = r_a_prod[2*SumW:SumW];
    assign q_mul = q_est * WinW;
    assign rem   = r_a_sum - q_mul[SumW-1:0];
    assign q_fin = (rem >= WinS) ? q_est + 1'b1 : q_est;

    always_ff @(posedge i_clk) begin
        if (en_a) begin
            r_a_prod <= (2*SumW+1)'(i_sum * RecipM);
            r_a_sum  <= i_sum;
            r_a_dur  <= i_dur;
        end
        if (en_b) begin
            r_b_item.avg   <= q_fin[15:0];
            r_b_item.pulse <= r_a_dur;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
        end else begin
            if (en_a) begin
                r_a_vld <= i_vld;
            end
            if (en_b) begin
                r_b_vld <= r_a_vld;
            end
        end
    end

    assign o_vld  = r_b_vld;
    assign o_item = r_b_item;

endmodule

### rtl/epda_scale.sv
module epda_scale
    import epda_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_vld,
    output logic        o_rdy,
    input  t_avg_item   i_item,
    input  logic [9:0]  i_thr,
    output logic        o_vld,
    input  logic        i_rdy,
    output t_result     o_res
);

    logic              r_a_vld;
    logic [36:0]       r_a_prod;
    t_avg_item         r_a_item;
    logic              r_a_near;
    logic              r_b_vld;
    t_result           r_b_res;

    logic              en_b;
    logic              en_a;
    logic [23:0]       avg_num;
    logic [23:0]       thr_den;
    logic [20:0]       est;
    logic [27:0]       est_mul;
    logic [27:0]       avg_mul;
    logic [27:0]       diff;
    logic [20:0]       dist_fin;

    assign en_b  = !r_b_vld || i_rdy;
    assign en_a  = !r_a_vld || en_b;
    assign o_rdy = en_a;

    assign avg_num = 24'(i_item.avg) * 24'(ScaleNum);
    assign thr_den = 24'(i_thr) * 24'(ScaleDen);

    assign est      = r_a_prod[DistRecipShift +: 21];
    assign est_mul  = 28'(est) * 28'(ScaleDen);
    assign avg_mul  = 28'(r_a_item.avg) * 28'(DistMul);
    assign diff     = avg_mul - est_mul;
    assign dist_fin = (diff >= 28'(ScaleDen)) ? est + 1'b1 : est;

    always_ff @(posedge i_clk) begin
        if (en_a) begin
            r_a_prod <= 37'(i_item.avg) * 37'(DistRecip);
            r_a_item <= i_item;
            r_a_near <= (avg_num <= thr_den);
        end
        if (en_b) begin
            r_b_res.near    <= r_a_near;
            r_b_res.dist_q4 <= dist_fin;
            r_b_res.avg     <= r_a_item.avg;
            r_b_res.pulse   <= r_a_item.pulse;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
        end else begin
            if (en_a) begin
                r_a_vld <= i_vld;
            end
            if (en_b) begin
                r_b_vld <= r_a_vld;
            end
        end
    end

    assign o_vld = r_b_vld;
    assign o_res = r_b_res;

endmodule

### rtl/echo_pulse_distance_alarm.sv
// A falling-edge transaction gives its result after it passes the ring, divider and scaling pipelines.
// A rising edge gives no result.
// One edge transaction is accepted per cycle unless the output stalls; the sample ring memory
// has one read and one write port, and the write of one event is forwarded to the next read.
// Synchronous active-low reset clears the start stamp and the ring slot, loads the running sum
// with the prefilled total, sets the threshold to 70 cm and marks every entry as 15000 ticks.
module echo_pulse_distance_alarm
    import epda_pkg::*;
#(
    parameter int WINDOW_LENGTH = WindowLenDef
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [15:0] i_s_axis_tdata,  // timer_count
    input  logic        i_s_axis_tuser,  // pin_level
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [55:0] o_m_axis_tdata,  // pulse_ticks, average_ticks, distance_q4, obstacle_near
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [9:0]  i_cfg_data
);

    localparam int SlotW = (WINDOW_LENGTH > 1) ? $clog2(WINDOW_LENGTH) : 1;
    localparam int SumW  = TimerW + ((WINDOW_LENGTH > 1) ? $clog2(WINDOW_LENGTH) : 0);
    localparam logic [SlotW-1:0] SlotLast = SlotW'(WINDOW_LENGTH - 1);

    logic [15:0]      r_start;
    logic [SlotW-1:0] r_slot;
    logic [9:0]       r_thr;

    logic             ring_vld;
    logic             ring_rdy;
    logic             accept;
    logic [15:0]      dur;
    logic             sum_vld;
    logic             sum_rdy;
    logic [SumW-1:0]  sum;
    logic [15:0]      sum_dur;
    logic             avg_vld;
    logic             avg_rdy;
    t_avg_item        avg_item;
    t_result          res;

    assign o_s_axis_tready = ring_rdy;
    assign accept          = i_s_axis_tvalid && ring_rdy;
    assign ring_vld        = i_s_axis_tvalid && !i_s_axis_tuser;
    assign dur             = i_s_axis_tdata - r_start;
    assign o_cfg_ready     = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start <= '0;
            r_slot  <= '0;
            r_thr   <= ThresholdRst;
        end else begin
            if (accept && i_s_axis_tuser) begin
                r_start <= i_s_axis_tdata;
            end
            if (accept && !i_s_axis_tuser) begin
                r_slot <= (r_slot == SlotLast) ? '0 : r_slot + 1'b1;
            end
            if (i_cfg_valid) begin
                r_thr <= i_cfg_data;
            end
        end
    end

    epda_ring #(
        .WINDOW_LENGTH(WINDOW_LENGTH),
        .SlotW        (SlotW),
        .SumW         (SumW)
    ) u_ring (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_vld  (ring_vld),
        .o_rdy  (ring_rdy),
        .i_dur  (dur),
        .i_addr (r_slot),
        .o_vld  (sum_vld),
        .i_rdy  (sum_rdy),
        .o_sum  (sum),
        .o_dur  (sum_dur)
    );

    epda_div #(
        .WINDOW_LENGTH(WINDOW_LENGTH),
        .SumW         (SumW)
    ) u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_vld  (sum_vld),
        .o_rdy  (sum_rdy),
        .i_sum  (sum),
        .i_dur  (sum_dur),
        .o_vld  (avg_vld),
        .i_rdy  (avg_rdy),
        .o_item (avg_item)
    );

    epda_scale u_scale (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_vld  (avg_vld),
        .o_rdy  (avg_rdy),
        .i_item (avg_item),
        .i_thr  (r_thr),
        .o_vld  (o_m_axis_tvalid),
        .i_rdy  (i_m_axis_tready),
        .o_res  (res)
    );

    assign o_m_axis_tdata = {2'b00, res};

endmodule

### tb/sv/echo_alarm_checker.sv
`timescale 1ns / 100ps

module echo_alarm_checker
    import epda_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [15:0] i_s_tdata,  // timer_count
    input  logic        i_s_tuser,  // pin_level
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [55:0] i_m_tdata,  // pulse_ticks, average_ticks, distance_q4, obstacle_near
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [9:0]  i_cfg_data,
    output int          o_errors,
    output int          o_pending
);

    localparam int          RingDepth   = 5;
    localparam logic [15:0] RingPrefill = 16'd15000;
    localparam logic [9:0]  AlarmRst    = 10'd70;
    localparam logic        EdgeRise    = 1'b1;

    logic [9:0]  alarm_cm;
    logic [15:0] pulse_start;
    logic [15:0] pulse_ring [RingDepth];
    int unsigned ring_slot;
    logic [18:0] ring_sum;
    t_result     expected_echoes [$];
    int          errors;

    task automatic note_falling_edge(input logic [15:0] stamp);
        logic [15:0] width;
        logic [15:0] mean;
        logic [31:0] scaled;
        t_result     echo;
        width = stamp - pulse_start;
        ring_sum = ring_sum - pulse_ring[ring_slot] + width;
        pulse_ring[ring_slot] = width;
        ring_slot = (ring_slot + 1) % RingDepth;
        mean = 16'(ring_sum / RingDepth);
        scaled = (32'(mean) * 32'd4064) / 32'd147;
        echo.pulse = width;
        echo.avg = mean;
        echo.dist_q4 = scaled[20:0];
        echo.near = (32'(mean) * 32'd254) <= (32'(alarm_cm) * 32'd147);
        expected_echoes.push_back(echo);
    endtask

    task automatic report_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
        if (got !== want) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    task automatic check_echo(input logic [55:0] word);
        t_result got;
        t_result want;
        got = t_result'(word[53:0]);
        if (expected_echoes.size() == 0) begin
            errors++;
            $display("%0t: unexpected transaction, expected none, actual %h", $time, word);
        end else begin
            want = expected_echoes.pop_front();
            report_field("pulse_ticks", 32'(want.pulse), 32'(got.pulse));
            report_field("average_ticks", 32'(want.avg), 32'(got.avg));
            report_field("distance_q4", 32'(want.dist_q4), 32'(got.dist_q4));
            report_field("obstacle_near", 32'(want.near), 32'(got.near));
            report_field("padding", 32'd0, 32'(word[55:54]));
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            alarm_cm = AlarmRst;
            pulse_start = '0;
            for (int k = 0; k < RingDepth; k++) begin
                pulse_ring[k] = RingPrefill;
            end
            ring_slot = 0;
            ring_sum = 19'(RingPrefill * RingDepth);
            expected_echoes.delete();
            errors = 0;
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                check_echo(i_m_tdata);
            end
            if (i_cfg_valid && i_cfg_ready) begin
                alarm_cm = i_cfg_data;
            end
            if (i_s_tvalid && i_s_tready) begin
                if (i_s_tuser == EdgeRise) begin
                    pulse_start = i_s_tdata;
                end else begin
                    note_falling_edge(i_s_tdata);
                end
            end
        end
        o_errors <= errors;
        o_pending <= expected_echoes.size();
    end

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import epda_pkg::*;

    localparam int   QuietLimit = 3000;
    localparam int   HoldCycles = 400;
    localparam int   PhaseItems = 450;
    localparam logic EdgeRise   = 1'b1;
    localparam logic EdgeFall   = 1'b0;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [15:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tready = 1'b0;
    logic        cfg_valid = 1'b0;
    logic [9:0]  cfg_data = '0;
    logic        s_tready;
    logic        m_tvalid;
    logic [55:0] m_tdata;
    logic        cfg_ready;

    int   send_idle_pct = 0;
    int   recv_stall_pct = 0;
    logic hold_req = 1'b0;
    logic hold_taken = 1'b0;
    int   hold_left = 0;
    int   quiet_cycles = 0;
    int   errors;
    int   pending;

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    echo_pulse_distance_alarm dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_data      (cfg_data)
    );

    echo_alarm_checker checker_inst (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_s_tvalid  (s_tvalid),
        .i_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .i_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .i_m_tdata   (m_tdata),
        .i_cfg_valid (cfg_valid),
        .i_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data),
        .o_errors    (errors),
        .o_pending   (pending)
    );

    // The long hold is counted here so that the sender keeps offering meanwhile.
    always @(posedge clk) begin
        if (hold_req && !hold_taken) begin
            hold_taken <= 1'b1;
            hold_left <= HoldCycles;
            m_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= !(recv_stall_pct != 0 && $urandom_range(99) < recv_stall_pct);
        end
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
                quiet_cycles <= 0;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
            if (quiet_cycles >= QuietLimit) begin
                $display("echo_pulse_distance_alarm regression: fail");
                $finish;
            end
        end
    end

    task automatic send_edge(input logic level, input logic [15:0] stamp);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= level;
        s_tdata <= stamp;
        do @(posedge clk); while (!s_tready);
    endtask

    task automatic drain_echoes();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic write_threshold(input logic [9:0] value);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_random_pulses(input int items);
        int          sent;
        int          pick;
        logic [15:0] start;
        logic [15:0] width;
        sent = 0;
        while (sent < items) begin
            pick = $urandom_range(99);
            if (pick < 85) begin
                start = 16'($urandom);
                pick = $urandom_range(99);
                if (pick < 55) begin
                    width = 16'($urandom_range(1200));
                end else if (pick < 85) begin
                    width = 16'($urandom);
                end else begin
                    width = 16'($urandom_range(16));
                end
                send_edge(EdgeRise, start);
                send_edge(EdgeFall, start + width);
                sent += 2;
            end else begin
                send_edge(1'($urandom_range(1)), 16'($urandom));
                sent++;
            end
        end
    endtask

    initial begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_edge(EdgeFall, 16'd100);
        send_edge(EdgeRise, 16'hFFF0);
        send_edge(EdgeFall, 16'h0010);
        send_edge(EdgeRise, 16'h0000);
        for (int k = 0; k < 5; k++) begin
            send_edge(EdgeFall, 16'hFFFF);
        end
        send_edge(EdgeRise, 16'd1234);
        for (int k = 0; k < 5; k++) begin
            send_edge(EdgeFall, 16'd1234);
        end
        send_edge(EdgeRise, 16'd1000);
        send_edge(EdgeRise, 16'd2000);
        for (int k = 0; k < 5; k++) begin
            send_edge(EdgeFall, 16'd2040);
        end
        send_edge(EdgeFall, 16'd2041);
        drain_echoes();

        write_threshold(10'd1023);
        send_random_pulses(PhaseItems);
        drain_echoes();

        write_threshold(10'd0);
        send_idle_pct = 76;
        send_random_pulses(PhaseItems);
        drain_echoes();

        write_threshold(10'($urandom_range(1023)));
        send_idle_pct = 0;
        recv_stall_pct = 76;
        send_random_pulses(PhaseItems);
        drain_echoes();

        write_threshold(10'($urandom_range(1023)));
        send_idle_pct = 21;
        recv_stall_pct = 21;
        send_random_pulses(PhaseItems);
        drain_echoes();

        write_threshold(10'd70);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_req <= 1'b1;
        send_random_pulses(300);
        drain_echoes();

        if (errors == 0) begin
            $display("echo_pulse_distance_alarm regression: pass");
        end else begin
            $display("echo_pulse_distance_alarm regression: fail");
        end
        $finish;
    end

endmodule
